@@ hdl/object_block_frame_parser_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the object block frame parser
// Implication checks sampled on the rising clock edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef OBJECT_BLOCK_FRAME_PARSER_MACROS_SVH
`define OBJECT_BLOCK_FRAME_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OBFP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OBFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/obfp_pkg.sv @@
// ---------------------------------------------------------------------------
// obfp_pkg
// Types and constants shared by the object block frame parser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package obfp_pkg;

    localparam int MAX_BLOCK_LIMIT = 10;
    localparam int LIMIT_W         = 8;

    localparam logic [15:0] W_START     = 16'haa55;
    localparam logic [15:0] W_START_CC  = 16'haa56;
    localparam logic [15:0] W_START_REV = 16'h55aa;
    localparam logic [15:0] W_NONE      = 16'hffff;

    localparam logic [2:0] WORDS_NORMAL = 3'd5;
    localparam logic [2:0] WORDS_CC     = 3'd6;

    typedef enum logic [1:0] {
        PH_HUNT     = 2'd0,
        PH_CHECKSUM = 2'd1,
        PH_FIELDS   = 2'd2,
        PH_TRAILER  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ACCEPT    = 2'd0,
        KIND_CKSUM_ERR = 2'd1,
        KIND_FRAME_END = 2'd2
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [3:0]  block_count;
        logic        color_coded;
        logic [15:0] rotation;
        logic [15:0] box_height;
        logic [15:0] box_width;
        logic [15:0] y_center;
        logic [15:0] x_center;
        logic [15:0] signature;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/obfp_core.sv @@
// ---------------------------------------------------------------------------
// obfp_core
// Byte pairing, frame hunt and block checksum state for the frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

module obfp_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            byte_accept,
    input  wire logic [7:0]      rx_byte,
    input  wire logic [3:0]      max_blocks,
    output obfp_pkg::result_t    res
);

    obfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  low_reg, low_next;
    logic        half_reg, half_next;
    logic        drop_reg, drop_next;
    logic [15:0] prev_reg, prev_next;
    logic [15:0] exp_reg, exp_next;
    logic [15:0] sum_reg, sum_next;
    logic [2:0]  idx_reg, idx_next;
    logic        color_reg, color_next;
    logic        resume_reg, resume_next;
    logic [3:0]  acc_reg, acc_next;

    logic [15:0] store_reg [6];
    logic        store_we;

    logic [15:0] word;
    logic        word_start;
    logic [obfp_pkg::LIMIT_W-1:0] limit;
    logic        limit_zero;
    logic        acc_at_limit;
    logic [15:0] sum_add;
    logic [2:0]  idx_inc;
    logic [15:0] fw [6];

    assign word       = {rx_byte, low_reg};
    assign word_start = (word == obfp_pkg::W_START) || (word == obfp_pkg::W_START_CC);
    assign limit      = ({4'd0, max_blocks} < obfp_pkg::LIMIT_W'(obfp_pkg::MAX_BLOCK_LIMIT))
                        ? {4'd0, max_blocks}
                        : obfp_pkg::LIMIT_W'(obfp_pkg::MAX_BLOCK_LIMIT);
    assign limit_zero   = (limit == '0);
    assign acc_at_limit = ({4'd0, acc_reg} >= limit);
    assign sum_add      = sum_reg + word;
    assign idx_inc      = idx_reg + 3'd1;

    // Block words as they stand once the current word lands in its slot.
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            fw[j] = (idx_reg == 3'(j)) ? word : store_reg[j];
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        low_next    = low_reg;
        half_next   = half_reg;
        drop_next   = drop_reg;
        prev_next   = prev_reg;
        exp_next    = exp_reg;
        sum_next    = sum_reg;
        idx_next    = idx_reg;
        color_next  = color_reg;
        resume_next = resume_reg;
        acc_next    = acc_reg;
        store_we    = 1'b0;
        res         = '0;

        if (byte_accept) begin
            if (drop_reg) begin
                drop_next = 1'b0;
            end else if (!half_reg) begin
                low_next  = rx_byte;
                half_next = 1'b1;
            end else begin
                half_next = 1'b0;
                unique case (phase_reg)
                    obfp_pkg::PH_HUNT: begin
                        if (resume_reg) begin
                            resume_next = 1'b0;
                            acc_next    = 4'd0;
                            if (limit_zero) begin
                                // Empty frame, then the word opens a fresh hunt.
                                res.valid = 1'b1;
                                res.kind  = obfp_pkg::KIND_FRAME_END;
                                phase_next = obfp_pkg::PH_HUNT;
                                if (word == obfp_pkg::W_START_REV) begin
                                    drop_next = 1'b1;
                                end
                                prev_next = word;
                            end else if (word_start) begin
                                resume_next = 1'b1;
                                color_next  = (word == obfp_pkg::W_START_CC);
                                res.valid   = 1'b1;
                                res.kind    = obfp_pkg::KIND_FRAME_END;
                                phase_next  = obfp_pkg::PH_HUNT;
                                prev_next   = obfp_pkg::W_NONE;
                            end else if (word == 16'd0) begin
                                res.valid  = 1'b1;
                                res.kind   = obfp_pkg::KIND_FRAME_END;
                                phase_next = obfp_pkg::PH_HUNT;
                                prev_next  = obfp_pkg::W_NONE;
                            end else begin
                                exp_next   = word;
                                sum_next   = 16'd0;
                                idx_next   = 3'd0;
                                phase_next = obfp_pkg::PH_FIELDS;
                            end
                        end else if (word == 16'd0 && prev_reg == 16'd0) begin
                            acc_next   = 4'd0;
                            res.valid  = 1'b1;
                            res.kind   = obfp_pkg::KIND_FRAME_END;
                            phase_next = obfp_pkg::PH_HUNT;
                            prev_next  = obfp_pkg::W_NONE;
                        end else if (prev_reg == obfp_pkg::W_START && word_start) begin
                            color_next = (word == obfp_pkg::W_START_CC);
                            acc_next   = 4'd0;
                            if (limit_zero) begin
                                res.valid  = 1'b1;
                                res.kind   = obfp_pkg::KIND_FRAME_END;
                                phase_next = obfp_pkg::PH_HUNT;
                                prev_next  = obfp_pkg::W_NONE;
                            end else begin
                                phase_next = obfp_pkg::PH_CHECKSUM;
                            end
                        end else begin
                            if (word == obfp_pkg::W_START_REV) begin
                                drop_next = 1'b1;
                            end
                            prev_next = word;
                        end
                    end
                    obfp_pkg::PH_CHECKSUM: begin
                        if (word_start) begin
                            // The next frame starts right at its checksum word.
                            resume_next     = 1'b1;
                            color_next      = (word == obfp_pkg::W_START_CC);
                            res.valid       = 1'b1;
                            res.kind        = obfp_pkg::KIND_FRAME_END;
                            res.block_count = acc_reg;
                            phase_next      = obfp_pkg::PH_HUNT;
                            prev_next       = obfp_pkg::W_NONE;
                        end else if (word == 16'd0) begin
                            res.valid       = 1'b1;
                            res.kind        = obfp_pkg::KIND_FRAME_END;
                            res.block_count = acc_reg;
                            phase_next      = obfp_pkg::PH_HUNT;
                            prev_next       = obfp_pkg::W_NONE;
                        end else begin
                            exp_next   = word;
                            sum_next   = 16'd0;
                            idx_next   = 3'd0;
                            phase_next = obfp_pkg::PH_FIELDS;
                        end
                    end
                    obfp_pkg::PH_FIELDS: begin
                        store_we = 1'b1;
                        sum_next = sum_add;
                        idx_next = idx_inc;
                        if (idx_inc >= (color_reg ? obfp_pkg::WORDS_CC
                                                  : obfp_pkg::WORDS_NORMAL)) begin
                            res.valid = 1'b1;
                            if (sum_add == exp_reg) begin
                                res.kind = obfp_pkg::KIND_ACCEPT;
                                acc_next = acc_reg + 4'd1;
                            end else begin
                                res.kind = obfp_pkg::KIND_CKSUM_ERR;
                            end
                            res.signature   = fw[0];
                            res.x_center    = fw[1];
                            res.y_center    = fw[2];
                            res.box_width   = fw[3];
                            res.box_height  = fw[4];
                            res.rotation    = color_reg ? fw[5] : 16'd0;
                            res.color_coded = color_reg;
                            phase_next      = obfp_pkg::PH_TRAILER;
                        end
                    end
                    obfp_pkg::PH_TRAILER: begin
                        if (word_start && !acc_at_limit) begin
                            color_next = (word == obfp_pkg::W_START_CC);
                            phase_next = obfp_pkg::PH_CHECKSUM;
                        end else begin
                            if (word_start) begin
                                color_next = (word == obfp_pkg::W_START_CC);
                            end
                            res.valid       = 1'b1;
                            res.kind        = obfp_pkg::KIND_FRAME_END;
                            res.block_count = acc_reg;
                            phase_next      = obfp_pkg::PH_HUNT;
                            prev_next       = obfp_pkg::W_NONE;
                        end
                    end
                    default: begin
                        phase_next = obfp_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= obfp_pkg::PH_HUNT;
            low_reg    <= 8'd0;
            half_reg   <= 1'b0;
            drop_reg   <= 1'b0;
            prev_reg   <= obfp_pkg::W_NONE;
            exp_reg    <= 16'd0;
            sum_reg    <= 16'd0;
            idx_reg    <= 3'd0;
            color_reg  <= 1'b0;
            resume_reg <= 1'b0;
            acc_reg    <= 4'd0;
        end else begin
            phase_reg  <= phase_next;
            low_reg    <= low_next;
            half_reg   <= half_next;
            drop_reg   <= drop_next;
            prev_reg   <= prev_next;
            exp_reg    <= exp_next;
            sum_reg    <= sum_next;
            idx_reg    <= idx_next;
            color_reg  <= color_next;
            resume_reg <= resume_next;
            acc_reg    <= acc_next;
        end
    end

    // Block word store: payload only, no reset.
    always_ff @(posedge aclk) begin
        if (store_we && idx_reg < 3'd6) begin
            store_reg[idx_reg] <= word;
        end
    end

endmodule

`default_nettype wire

@@ hdl/object_block_frame_parser.sv @@
// ---------------------------------------------------------------------------
// object_block_frame_parser
// Parses a camera object block byte stream into block and frame end results.
// ---------------------------------------------------------------------------
// Usage:
// Bytes from the camera link enter on the s_ channel, one byte per request.
// Results leave on the m_ channel; m_tuser holds the result kind (block
// accepted, block checksum error, frame end) and m_tdata the block words,
// the color-coded flag and, on frame end, the accepted block count.
// The cfg_ channel writes max_blocks; it is always ready and must only be
// written while no result is pending.
// A result appears on m_ in the cycle after the byte that completes it is
// accepted. Throughput: one byte per cycle, unless the receiver stalls with
// a result held.
// Each byte yields at most one result, and most bytes yield none.
// When the receiver stalls with a result held, s_tready drops until that
// result is taken; a result taken in the same cycle lets a new byte in.
// Reset clears the parser to hunting for a frame start, empties the result
// register and sets max_blocks to 1.
// ---------------------------------------------------------------------------
`default_nettype none

`include "object_block_frame_parser_macros.svh"

module object_block_frame_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // [15:0] signature, [31:16] x_center,
                                         // [47:32] y_center, [63:48] box_width,
                                         // [79:64] box_height, [95:80] rotation,
                                         // [96] color_coded, [100:97] block_count
    output logic [1:0]        m_tuser,   // [1:0] result_kind
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [3:0]   cfg_data   // [3:0] max_blocks
);

    logic              s_accept;
    logic [3:0]        max_blocks_reg;
    obfp_pkg::result_t res;
    obfp_pkg::result_t out_reg;
    logic              m_valid_reg, m_valid_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_blocks_reg <= 4'd1;
        end else if (cfg_valid && cfg_ready) begin
            max_blocks_reg <= cfg_data;
        end
    end

    obfp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .rx_byte     (s_tdata),
        .max_blocks  (max_blocks_reg),
        .res         (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = res.valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {3'd0, out_reg.block_count, out_reg.color_coded,
                       out_reg.rotation, out_reg.box_height, out_reg.box_width,
                       out_reg.y_center, out_reg.x_center, out_reg.signature};

    `OBFP_ASSERT_SAME(a_end_no_fields, aclk, aresetn,
        m_tvalid && m_tuser == obfp_pkg::KIND_FRAME_END, m_tdata[96:0] == 97'd0,
        "frame end carries block fields")
    `OBFP_ASSERT_SAME(a_block_no_count, aclk, aresetn,
        m_tvalid && m_tuser != obfp_pkg::KIND_FRAME_END, m_tdata[100:97] == 4'd0,
        "block result carries a count")
    `OBFP_ASSERT_SAME(a_ready_when_empty, aclk, aresetn,
        !m_tvalid, s_tready,
        "input stalled while result register is empty")
    `OBFP_ASSERT_NEXT(a_stall_blocks_input, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid,
        "held result lost during stall")

endmodule

`default_nettype wire
